>>> rtl/core/rpn_calc_pkg.sv
// ----------------------------------------------------------------------------
// rpn_calc_pkg
// Shared types and constants of the postfix calculator core: character codes,
// status codes, controller states and the control and status bundles.
// ----------------------------------------------------------------------------
package rpn_calc_pkg;

    // Default number of stack entries
    localparam int DEF_STACK_DEPTH = 16;

    // Character codes of the expression alphabet
    localparam logic [7:0] CHAR_ZERO  = 8'h30;
    localparam logic [7:0] CHAR_NINE  = 8'h39;
    localparam logic [7:0] CHAR_PLUS  = 8'h2B;
    localparam logic [7:0] CHAR_MINUS = 8'h2D;
    localparam logic [7:0] CHAR_STAR  = 8'h2A;
    localparam logic [7:0] CHAR_SLASH = 8'h2F;

    // Result status codes
    typedef enum logic [2:0] {
        STAT_OK        = 3'd0,
        STAT_UNDERFLOW = 3'd1,
        STAT_DIV_ZERO  = 3'd2,
        STAT_FULL      = 3'd3,
        STAT_IGNORED   = 3'd4
    } status_t;

    // Controller states
    typedef enum logic [2:0] {
        ST_IDLE,
        ST_DECODE,
        ST_READ,
        ST_DIV,
        ST_FINISH
    } state_t;

    // Commands from the controller to the datapath
    typedef struct packed {
        logic    load;       // latch the incoming item, clear stack on new expression
        logic    push;       // push the digit value
        logic    alu_write;  // replace the two top entries by the ALU result
        logic    div_start;  // launch the divider
        logic    div_write;  // replace the two top entries by the quotient
        logic    out_load;   // capture the result item
        status_t status;     // status of the result item
    } ctrl_cmd_t;

    // Status from the datapath to the controller
    typedef struct packed {
        logic is_digit;
        logic is_op;
        logic is_div;
        logic full;
        logic under;
        logic top_zero;
        logic div_done;
    } dp_stat_t;

endpackage

>>> rtl/core/rpn_calc_ram.sv
// ----------------------------------------------------------------------------
// rpn_calc_ram
// Generic single-write, single-read RAM with a registered read port.
// ----------------------------------------------------------------------------
module rpn_calc_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     clk,
    input  logic                     wr_en,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  logic [WIDTH-1:0]         wr_data,
    input  logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];

    // Write port
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
    end

    // Registered read port
    always_ff @(posedge clk)
    begin
        rd_data <= mem[rd_addr];
    end

endmodule

>>> rtl/core/rpn_calc_div.sv
// ----------------------------------------------------------------------------
// rpn_calc_div
// Iterative signed 8-bit divider, one restoring step per cycle, quotient
// truncated toward zero and wrapped to 8 bits.
// ----------------------------------------------------------------------------
module rpn_calc_div (
    input  logic       clk,
    input  logic       rst_n,
    input  logic       start,
    input  logic [7:0] dividend,
    input  logic [7:0] divisor,
    output logic       done,
    output logic [7:0] quotient
);

    logic       busy_reg, busy_next;
    logic       done_reg, done_next;
    logic [2:0] cnt_reg, cnt_next;
    logic [7:0] rem_reg, rem_next;
    logic [7:0] quo_reg, quo_next;
    logic [7:0] den_reg, den_next;
    logic       neg_reg, neg_next;
    logic [8:0] rem_shift;
    logic [7:0] mag_a;
    logic [7:0] mag_b;

    // Take magnitudes; -128 maps to 128 as unsigned
    assign mag_a = dividend[7] ? (~dividend + 8'd1) : dividend;
    assign mag_b = divisor[7]  ? (~divisor + 8'd1)  : divisor;

    // Shift in the next dividend bit
    assign rem_shift = {rem_reg, quo_reg[7]};

    // Step the restoring division
    always_comb
    begin
        busy_next = busy_reg;
        done_next = 1'b0;
        cnt_next  = cnt_reg;
        rem_next  = rem_reg;
        quo_next  = quo_reg;
        den_next  = den_reg;
        neg_next  = neg_reg;
        if (start)
        begin
            busy_next = 1'b1;
            cnt_next  = 3'd0;
            rem_next  = 8'd0;
            quo_next  = mag_a;
            den_next  = mag_b;
            neg_next  = dividend[7] ^ divisor[7];
        end
        else if (busy_reg)
        begin
            if (rem_shift >= {1'b0, den_reg})
            begin
                rem_next = 8'(rem_shift - {1'b0, den_reg});
                quo_next = {quo_reg[6:0], 1'b1};
            end
            else
            begin
                rem_next = rem_shift[7:0];
                quo_next = {quo_reg[6:0], 1'b0};
            end
            cnt_next = cnt_reg + 3'd1;
            if (cnt_reg == 3'd7)
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    // Hold control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= 3'd0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
    end

    // Hold operands and partial results
    always_ff @(posedge clk)
    begin
        rem_reg <= rem_next;
        quo_reg <= quo_next;
        den_reg <= den_next;
        neg_reg <= neg_next;
    end

    // Apply the sign
    assign done     = done_reg;
    assign quotient = neg_reg ? (~quo_reg + 8'd1) : quo_reg;

endmodule

>>> rtl/core/rpn_calc_dp.sv
// ----------------------------------------------------------------------------
// rpn_calc_dp
// Datapath of the postfix calculator: item latch, stack RAM with a cached top
// entry, ALU, divider and the result register.
// ----------------------------------------------------------------------------
module rpn_calc_dp #(
    parameter int STACK_DEPTH = rpn_calc_pkg::DEF_STACK_DEPTH
) (
    input  logic                     clk,
    input  logic                     rst_n,
    input  logic [7:0]               char_code,
    input  logic                     new_expression,
    input  rpn_calc_pkg::ctrl_cmd_t  cmd,
    output rpn_calc_pkg::dp_stat_t   stat,
    output logic signed [7:0]        top_value,
    output logic [4:0]               depth,
    output logic [2:0]               status
);

    localparam int AW = $clog2(STACK_DEPTH);
    localparam int CW = $clog2(STACK_DEPTH + 1);

    logic [7:0]              char_reg;
    logic [CW-1:0]           count_reg, count_next;
    logic [7:0]              top_reg, top_next;
    logic [7:0]              out_top_reg;
    logic [4:0]              out_depth_reg;
    rpn_calc_pkg::status_t   out_status_reg;

    logic [CW-1:0]           second_idx;
    logic [7:0]              second_val;
    logic [7:0]              digit_val;
    logic signed [15:0]      product;
    logic [7:0]              alu_result;
    logic [7:0]              quotient;
    logic                    div_done;
    logic                    wr_en;
    logic [AW-1:0]           wr_addr;
    logic [7:0]              wr_data;
    logic [CW+4:0]           depth_ext;

    assign second_idx = count_reg - CW'(2);
    assign digit_val  = char_reg - rpn_calc_pkg::CHAR_ZERO;

    // Stack storage of every entry, the top included; the top is also cached
    rpn_calc_ram #(
        .WIDTH (8),
        .DEPTH (STACK_DEPTH)
    ) u_stack (
        .clk     (clk),
        .wr_en   (wr_en),
        .wr_addr (wr_addr),
        .wr_data (wr_data),
        .rd_addr (second_idx[AW-1:0]),
        .rd_data (second_val)
    );

    // Divide second by top
    rpn_calc_div u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (cmd.div_start),
        .dividend (second_val),
        .divisor  (top_reg),
        .done     (div_done),
        .quotient (quotient)
    );

    // Compute add, subtract and multiply, wrapped to 8 bits
    assign product = $signed(second_val) * $signed(top_reg);

    always_comb
    begin
        case (char_reg)
            rpn_calc_pkg::CHAR_PLUS:  alu_result = second_val + top_reg;
            rpn_calc_pkg::CHAR_MINUS: alu_result = second_val - top_reg;
            rpn_calc_pkg::CHAR_STAR:  alu_result = product[7:0];
            default:                  alu_result = second_val + top_reg;
        endcase
    end

    // Select the stack write
    always_comb
    begin
        wr_en   = cmd.push | cmd.alu_write | cmd.div_write;
        wr_addr = second_idx[AW-1:0];
        wr_data = cmd.div_write ? quotient : alu_result;
        if (cmd.push)
        begin
            wr_addr = count_reg[AW-1:0];
            wr_data = digit_val;
        end
    end

    // Advance depth and the cached top
    always_comb
    begin
        count_next = count_reg;
        top_next   = top_reg;
        if (cmd.load && new_expression)
        begin
            count_next = '0;
        end
        if (cmd.push)
        begin
            count_next = count_reg + CW'(1);
            top_next   = digit_val;
        end
        if (cmd.alu_write)
        begin
            count_next = count_reg - CW'(1);
            top_next   = alu_result;
        end
        if (cmd.div_write)
        begin
            count_next = count_reg - CW'(1);
            top_next   = quotient;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg <= '0;
        end
        else
        begin
            count_reg <= count_next;
        end
    end

    // Hold the item, the cached top and the result
    assign depth_ext = (CW + 5)'(count_reg);

    always_ff @(posedge clk)
    begin
        top_reg <= top_next;
        if (cmd.load)
        begin
            char_reg <= char_code;
        end
        if (cmd.out_load)
        begin
            out_top_reg    <= (count_reg != '0) ? top_reg : 8'd0;
            out_depth_reg  <= depth_ext[4:0];
            out_status_reg <= cmd.status;
        end
    end

    // Classify the item and the stack
    always_comb
    begin
        stat.is_digit = char_reg inside {[rpn_calc_pkg::CHAR_ZERO:rpn_calc_pkg::CHAR_NINE]};
        stat.is_op    = char_reg inside {rpn_calc_pkg::CHAR_PLUS, rpn_calc_pkg::CHAR_MINUS,
                                         rpn_calc_pkg::CHAR_STAR, rpn_calc_pkg::CHAR_SLASH};
        stat.is_div   = (char_reg == rpn_calc_pkg::CHAR_SLASH);
        stat.full     = (count_reg >= CW'(STACK_DEPTH));
        stat.under    = (count_reg < CW'(2));
        stat.top_zero = (top_reg == 8'd0);
        stat.div_done = div_done;
    end

    assign top_value = out_top_reg;
    assign depth     = out_depth_reg;
    assign status    = out_status_reg;

endmodule

>>> rtl/core/rpn_calc_ctrl.sv
// ----------------------------------------------------------------------------
// rpn_calc_ctrl
// Controller of the postfix calculator: sequences decode, operand read,
// arithmetic and result delivery for one item at a time.
// ----------------------------------------------------------------------------
module rpn_calc_ctrl (
    input  logic                     clk,
    input  logic                     rst_n,
    input  logic                     in_valid,
    output logic                     in_stall,
    output logic                     out_valid,
    input  logic                     out_stall,
    input  rpn_calc_pkg::dp_stat_t   stat,
    output rpn_calc_pkg::ctrl_cmd_t  cmd
);

    rpn_calc_pkg::state_t  state_reg, state_next;
    rpn_calc_pkg::status_t status_reg, status_next;
    logic                  out_valid_reg, out_valid_next;

    // Hold state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= rpn_calc_pkg::ST_IDLE;
            status_reg    <= rpn_calc_pkg::STAT_OK;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            status_reg    <= status_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // Sequence one item and issue commands
    always_comb
    begin
        state_next  = state_reg;
        status_next = status_reg;
        cmd         = '0;
        cmd.status  = status_reg;
        case (state_reg)
            rpn_calc_pkg::ST_IDLE:
            begin
                if (in_valid)
                begin
                    cmd.load   = 1'b1;
                    state_next = rpn_calc_pkg::ST_DECODE;
                end
            end
            rpn_calc_pkg::ST_DECODE:
            begin
                state_next  = rpn_calc_pkg::ST_FINISH;
                status_next = rpn_calc_pkg::STAT_OK;
                if (stat.is_digit)
                begin
                    if (stat.full)
                    begin
                        status_next = rpn_calc_pkg::STAT_FULL;
                    end
                    else
                    begin
                        cmd.push = 1'b1;
                    end
                end
                else if (!stat.is_op)
                begin
                    status_next = rpn_calc_pkg::STAT_IGNORED;
                end
                else if (stat.under)
                begin
                    status_next = rpn_calc_pkg::STAT_UNDERFLOW;
                end
                else if (stat.is_div && stat.top_zero)
                begin
                    status_next = rpn_calc_pkg::STAT_DIV_ZERO;
                end
                else
                begin
                    state_next = rpn_calc_pkg::ST_READ;
                end
            end
            rpn_calc_pkg::ST_READ:
            begin
                if (stat.is_div)
                begin
                    cmd.div_start = 1'b1;
                    state_next    = rpn_calc_pkg::ST_DIV;
                end
                else
                begin
                    cmd.alu_write = 1'b1;
                    state_next    = rpn_calc_pkg::ST_FINISH;
                end
            end
            rpn_calc_pkg::ST_DIV:
            begin
                if (stat.div_done)
                begin
                    cmd.div_write = 1'b1;
                    state_next    = rpn_calc_pkg::ST_FINISH;
                end
            end
            rpn_calc_pkg::ST_FINISH:
            begin
                if (!out_valid_reg || !out_stall)
                begin
                    cmd.out_load = 1'b1;
                    state_next   = rpn_calc_pkg::ST_IDLE;
                end
            end
            default:
            begin
                state_next = rpn_calc_pkg::ST_IDLE;
            end
        endcase
    end

    // Drop the result when taken, raise it when loaded
    assign out_valid_next = cmd.out_load | (out_valid_reg & out_stall);

    assign in_stall  = (state_reg != rpn_calc_pkg::ST_IDLE);
    assign out_valid = out_valid_reg;

endmodule

>>> rtl/core/rpn_digit_stack_calculator_core.sv
// ----------------------------------------------------------------------------
// rpn_digit_stack_calculator_core
// Postfix calculator over a stack of signed 8-bit values, one character per
// item, one result item (top, depth, status) per character.
// ----------------------------------------------------------------------------
// The block takes one item at a time. A digit, an ignored character or an
// erroring operator goes from decode straight to finish; '+', '-' and '*'
// pass through a read state first (the second entry comes from the stack
// RAM's registered read port), and '/' also waits in a divide state for the
// eight-step iterative divider. The result sits in an output register, so the next item
// is accepted while a result still waits to be taken; the block only holds
// off finishing an item while the previous result is still there.
module rpn_digit_stack_calculator_core #(
    parameter int STACK_DEPTH = rpn_calc_pkg::DEF_STACK_DEPTH
) (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              in_valid,
    output logic              in_stall,
    input  logic [7:0]        char_code,
    input  logic              new_expression,
    output logic              out_valid,
    input  logic              out_stall,
    output logic signed [7:0] top_value,
    output logic [4:0]        depth,
    output logic [2:0]        status
);

    rpn_calc_pkg::ctrl_cmd_t cmd;
    rpn_calc_pkg::dp_stat_t  stat;

    // Sequence items
    rpn_calc_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .stat      (stat),
        .cmd       (cmd)
    );

    // Hold the stack and compute
    rpn_calc_dp #(
        .STACK_DEPTH (STACK_DEPTH)
    ) u_dp (
        .clk            (clk),
        .rst_n          (rst_n),
        .char_code      (char_code),
        .new_expression (new_expression),
        .cmd            (cmd),
        .stat           (stat),
        .top_value      (top_value),
        .depth          (depth),
        .status         (status)
    );

    // One item at a time: an accepted item blocks the input next cycle
    a_one_item: assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid && !in_stall) |=> in_stall)
        else $error("input accepted while an item is in progress");

    // An empty stack reports a zero top
    a_empty_top: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && depth == 5'd0 && STACK_DEPTH < 32) |-> (top_value == 8'sd0))
        else $error("empty stack reports a nonzero top");

    // The divider only finishes for a division item
    a_div_only: assert property (@(posedge clk) disable iff (!rst_n)
        stat.div_done |-> stat.is_div)
        else $error("divider finished for a non-division item");

    // A division never starts with a zero divisor
    a_div_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.div_start |-> !stat.top_zero)
        else $error("division started with a zero divisor");

endmodule

>>> dv/rpn_calc_checker.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// rpn_calc_checker
// Watches both channels of the postfix calculator core. It keeps its own copy
// of the value stack and predicts one result item per accepted character.
// Each accepted result is compared field by field with the oldest prediction.
// ----------------------------------------------------------------------------
module rpn_calc_checker #(
    parameter int STACK_DEPTH = rpn_calc_pkg::DEF_STACK_DEPTH
) (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              in_valid,
    input  logic              in_stall,
    input  logic [7:0]        char_code,
    input  logic              new_expression,
    input  logic              out_valid,
    input  logic              out_stall,
    input  logic signed [7:0] top_value,
    input  logic [4:0]        depth,
    input  logic [2:0]        status,
    output int                fail_count,
    output int                outstanding,
    output int                checked_count,
    output logic [4:0]        status_hit
);

    typedef struct {
        logic signed [7:0]     top;
        logic [4:0]            depth;
        rpn_calc_pkg::status_t code;
    } calc_result_t;

    calc_result_t      expected_results [$];
    calc_result_t      want;
    logic signed [7:0] calc_stack [STACK_DEPTH];
    int                calc_depth;

    // Apply one character to the shadow stack and return the result it gives
    function automatic calc_result_t eval_char(input logic [7:0] c, input logic clear);
        calc_result_t res;
        int           a;
        int           b;
        int           r;
        res.code = rpn_calc_pkg::STAT_OK;
        r = 0;
        if (clear)
            calc_depth = 0;
        if (c >= rpn_calc_pkg::CHAR_ZERO && c <= rpn_calc_pkg::CHAR_NINE)
        begin
            if (calc_depth >= STACK_DEPTH)
                res.code = rpn_calc_pkg::STAT_FULL;
            else
            begin
                calc_stack[calc_depth] = c - rpn_calc_pkg::CHAR_ZERO;
                calc_depth++;
            end
        end
        else if (c == rpn_calc_pkg::CHAR_PLUS || c == rpn_calc_pkg::CHAR_MINUS ||
                 c == rpn_calc_pkg::CHAR_STAR || c == rpn_calc_pkg::CHAR_SLASH)
        begin
            if (calc_depth < 2)
                res.code = rpn_calc_pkg::STAT_UNDERFLOW;
            else
            begin
                b = calc_stack[calc_depth - 1];
                a = calc_stack[calc_depth - 2];
                if (c == rpn_calc_pkg::CHAR_SLASH && b == 0)
                    res.code = rpn_calc_pkg::STAT_DIV_ZERO;
                else
                begin
                    // Wide math, then wrap to 8 bits (covers -128 / -1)
                    case (c)
                        rpn_calc_pkg::CHAR_PLUS:  r = a + b;
                        rpn_calc_pkg::CHAR_MINUS: r = a - b;
                        rpn_calc_pkg::CHAR_STAR:  r = a * b;
                        default:                  r = a / b;
                    endcase
                    calc_depth--;
                    calc_stack[calc_depth - 1] = r[7:0];
                end
            end
        end
        else
            res.code = rpn_calc_pkg::STAT_IGNORED;
        res.top   = (calc_depth > 0) ? calc_stack[calc_depth - 1] : 8'sd0;
        res.depth = calc_depth[4:0];
        return res;
    endfunction

    // Print one mismatch line and count it
    task automatic report_mismatch(input string msg);
        $display("[%0t] MISMATCH: %s", $realtime, msg);
        fail_count++;
    endtask

    // Retire results first, then queue the prediction for a new item
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            expected_results.delete();
            calc_depth    = 0;
            outstanding   = 0;
            fail_count    = 0;
            checked_count = 0;
            status_hit    = '0;
        end
        else
        begin
            if (out_valid && !out_stall)
            begin
                checked_count++;
                if (expected_results.size() == 0)
                    report_mismatch($sformatf(
                        "result with none pending: top %0d depth %0d status %0d",
                        top_value, depth, status));
                else
                begin
                    want = expected_results.pop_front();
                    status_hit[want.code] = 1'b1;
                    if (top_value !== want.top)
                        report_mismatch($sformatf("top_value expected %0d got %0d",
                                                  want.top, top_value));
                    if (depth !== want.depth)
                        report_mismatch($sformatf("depth expected %0d got %0d",
                                                  want.depth, depth));
                    if (status !== want.code)
                        report_mismatch($sformatf("status expected %0d got %0d",
                                                  want.code, status));
                end
            end
            if (in_valid && !in_stall)
                expected_results.push_back(eval_char(char_code, new_expression));
            outstanding = expected_results.size();
        end
    end

endmodule

>>> dv/tb.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb
// Stimulus and verdict for the postfix calculator core. A directed sequence
// hits the field extremes and every error case, then random postfix
// expressions mixed with noise bytes run with random idling on both sides.
// ----------------------------------------------------------------------------
module tb;

    logic              clk            = 1'b0;
    logic              rst_n          = 1'b0;
    logic              in_valid       = 1'b0;
    logic              in_stall;
    logic [7:0]        char_code      = 8'h00;
    logic              new_expression = 1'b0;
    logic              out_valid;
    logic              out_stall      = 1'b0;
    logic signed [7:0] top_value;
    logic [4:0]        depth;
    logic [2:0]        status;

    int         fail_count;
    int         outstanding;
    int         checked_count;
    logic [4:0] status_hit;

    int sent_count;
    int calc_items;
    bit quiet;
    bit sender_calm;

    rpn_digit_stack_calculator_core uut (
        .clk            (clk),
        .rst_n          (rst_n),
        .in_valid       (in_valid),
        .in_stall       (in_stall),
        .char_code      (char_code),
        .new_expression (new_expression),
        .out_valid      (out_valid),
        .out_stall      (out_stall),
        .top_value      (top_value),
        .depth          (depth),
        .status         (status)
    );

    rpn_calc_checker calc_check (
        .clk            (clk),
        .rst_n          (rst_n),
        .in_valid       (in_valid),
        .in_stall       (in_stall),
        .char_code      (char_code),
        .new_expression (new_expression),
        .out_valid      (out_valid),
        .out_stall      (out_stall),
        .top_value      (top_value),
        .depth          (depth),
        .status         (status),
        .fail_count     (fail_count),
        .outstanding    (outstanding),
        .checked_count  (checked_count),
        .status_hit     (status_hit)
    );

    // Clock generator
    initial
    begin
        forever #4 clk = ~clk;
    end

    // Watchdog
    initial
    begin
        #5_000_000;
        $display("rpn_digit_stack_calculator_core test failed");
        $finish;
    end

    // Result side: stall in random bursts, none in the last part
    initial
    begin
        wait (rst_n);
        @(posedge clk);
        forever
        begin
            if (!quiet && $urandom_range(0, 2) == 0)
            begin
                out_stall <= 1'b1;
                repeat ($urandom_range(1, 16)) @(posedge clk);
            end
            out_stall <= 1'b0;
            if ($urandom_range(0, 7) == 0)
                repeat ($urandom_range(32, 96)) @(posedge clk);
            else
                repeat ($urandom_range(1, 16)) @(posedge clk);
        end
    end

    function automatic logic [7:0] rand_digit();
        return 8'(rpn_calc_pkg::CHAR_ZERO + $urandom_range(0, 9));
    endfunction

    function automatic logic [7:0] rand_op();
        case ($urandom_range(0, 3))
            0:       return rpn_calc_pkg::CHAR_PLUS;
            1:       return rpn_calc_pkg::CHAR_MINUS;
            2:       return rpn_calc_pkg::CHAR_STAR;
            default: return rpn_calc_pkg::CHAR_SLASH;
        endcase
    endfunction

    // Offer one item, hold it until accepted, then maybe idle
    task automatic send_char(input logic [7:0] c, input logic clear);
        in_valid       <= 1'b1;
        char_code      <= c;
        new_expression <= clear;
        @(posedge clk);
        while (in_stall)
            @(posedge clk);
        sent_count++;
        if ((c >= rpn_calc_pkg::CHAR_ZERO && c <= rpn_calc_pkg::CHAR_NINE) ||
            c == rpn_calc_pkg::CHAR_PLUS || c == rpn_calc_pkg::CHAR_MINUS ||
            c == rpn_calc_pkg::CHAR_STAR || c == rpn_calc_pkg::CHAR_SLASH)
            calc_items++;
        if (!quiet && !sender_calm && $urandom_range(0, 3) == 0)
        begin
            in_valid <= 1'b0;
            repeat ($urandom_range(1, 16)) @(posedge clk);
        end
    endtask

    // Hold off until every predicted result has come back
    task automatic drain_results();
        in_valid <= 1'b0;
        @(negedge clk);
        while (outstanding != 0)
            @(negedge clk);
        @(posedge clk);
    endtask

    // One random postfix expression; deep ones run the stack into full
    task automatic run_expression();
        int d;
        int pick;
        d = 1;
        send_char(rand_digit(), 1'b1);
        if ($urandom_range(0, 7) == 0)
        begin
            repeat ($urandom_range(14, 19))
            begin
                send_char(rand_digit(), 1'b0);
                if (d < 16)
                    d++;
            end
        end
        repeat ($urandom_range(2, 20))
        begin
            pick = $urandom_range(0, 19);
            if (pick == 0)
                send_char(8'($urandom_range(0, 255)), 1'b0);
            else if (pick == 1 || (d >= 2 && (pick < 11 || d >= 16)))
            begin
                send_char(rand_op(), 1'b0);
                if (d >= 2)
                    d--;
            end
            else
            begin
                send_char(rand_digit(), 1'b0);
                if (d < 16)
                    d++;
            end
        end
    endtask

    // Main stimulus
    initial
    begin
        sender_calm = 1'b0;
        quiet       = 1'b0;
        repeat (5) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed: errors on a small stack
        send_char(8'(rpn_calc_pkg::CHAR_ZERO + 9), 1'b1);
        send_char(rpn_calc_pkg::CHAR_ZERO, 1'b0);
        send_char(rpn_calc_pkg::CHAR_SLASH, 1'b0);
        send_char(rpn_calc_pkg::CHAR_PLUS, 1'b0);
        send_char(rpn_calc_pkg::CHAR_MINUS, 1'b0);
        send_char(8'hFF, 1'b1);
        send_char(rpn_calc_pkg::CHAR_STAR, 1'b0);
        send_char(8'h00, 1'b0);
        // Build -128, then divide it by -1
        send_char(8'(rpn_calc_pkg::CHAR_ZERO + 8), 1'b1);
        send_char(8'(rpn_calc_pkg::CHAR_ZERO + 8), 1'b0);
        send_char(rpn_calc_pkg::CHAR_STAR, 1'b0);
        send_char(8'(rpn_calc_pkg::CHAR_ZERO + 2), 1'b0);
        send_char(rpn_calc_pkg::CHAR_STAR, 1'b0);
        send_char(rpn_calc_pkg::CHAR_ZERO, 1'b0);
        send_char(8'(rpn_calc_pkg::CHAR_ZERO + 1), 1'b0);
        send_char(rpn_calc_pkg::CHAR_MINUS, 1'b0);
        send_char(rpn_calc_pkg::CHAR_SLASH, 1'b0);
        // Fill the stack, then push once more
        for (int i = 0; i < 15; i++)
            send_char(8'(rpn_calc_pkg::CHAR_ZERO + (i % 10)), 1'b0);
        send_char(8'(rpn_calc_pkg::CHAR_ZERO + 5), 1'b0);
        drain_results();

        // Random expressions with noise bytes in between
        while (calc_items < 1200)
        begin
            if (calc_items >= 1050)
                quiet = 1'b1;
            sender_calm = ($urandom_range(0, 4) == 0);
            if ($urandom_range(0, 5) == 0)
                send_char(8'($urandom_range(0, 255)), 1'($urandom_range(0, 1)));
            else
                run_expression();
            if ($urandom_range(0, 39) == 0)
                drain_results();
        end

        // Wait out the tail, then give the verdict
        drain_results();
        repeat (20) @(posedge clk);
        @(negedge clk);
        $display("Summary: %0d characters sent, %0d digits or operators, %0d results checked",
                 sent_count, calc_items, checked_count);
        $display("Summary: status codes seen (bit per code, 4..0): %b", status_hit);
        if (fail_count == 0 && outstanding == 0)
            $display("rpn_digit_stack_calculator_core test passed");
        else
            $display("rpn_digit_stack_calculator_core test failed");
        $finish;
    end

endmodule

>>> filelist.f
rtl/core/rpn_calc_pkg.sv
rtl/core/rpn_calc_ram.sv
rtl/core/rpn_calc_div.sv
rtl/core/rpn_calc_dp.sv
rtl/core/rpn_calc_ctrl.sv
rtl/core/rpn_digit_stack_calculator_core.sv
dv/rpn_calc_checker.sv
dv/tb.sv
